// ===== src/dtw_pkg.sv =====
// shared types and constants of the ds-twr distance unit
`timescale 1ns / 1ps
`default_nettype none

package dtw_pkg;

	// configuration port
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MM_PER_TICK = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_CM   = 2'd1;

	localparam logic [31:0] MM_PER_TICK_RESET = 32'd78691015;
	localparam logic [15:0] OFFSET_CM_RESET   = 16'd0;

	// 20000 m in mm, scaled by the q24 fraction of the product
	localparam logic [63:0] FAR_LIMIT_Q24 = 64'd20000000 << 24;
	localparam logic [40:0] FAR_VALUE_MM  = -41'sd1000;

	localparam logic [31:0] DIST_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] DIST_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] tag_poll_tx;
		logic [31:0] tag_resp_rx;
		logic [31:0] tag_final_tx;
		logic [31:0] anchor_poll_rx;
		logic [31:0] anchor_resp_tx;
		logic [31:0] anchor_final_rx;
	} stamps_t;

	typedef struct packed {
		logic signed [31:0] flight_ticks;
		logic signed [31:0] distance_mm;
		logic               too_far;
		logic               zero_divisor;
	} result_t;

endpackage

`default_nettype wire

// ===== src/ds_twr_distance_unit.sv =====
// top level of the double-sided two-way ranging distance unit
//
// Input: an item of six radio timestamps is taken on stamps at a clock edge
// with push high and full low. Results: while empty is low the oldest result
// (flight ticks, distance in mm, too-far and zero-divisor flags) sits on
// result; pop at such an edge takes it. Configuration: cfg_index/cfg_data are
// written when cfg_valid is high; cfg_ready is always high. Index 0 holds the
// q8.24 millimetres per tick, index 1 the offset in centimetres.
// Throughput is one item per cycle while full is low. From push, an item
// passes the front end, the middle queue, the restoring divider with one
// quotient bit per stage and the tail before pop can take the result.
// A queue sits between the front end (intervals and products) and the back
// end (divider and scaling), and a second one holds finished results. When
// the receiver stops popping, the back end stalls once its output queue is
// full, then the middle queue fills and full rises; no item is dropped.
// Reset empties both queues and pipelines and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module ds_twr_distance_unit import dtw_pkg::*; #(
	parameter int STAMP_BITS = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire stamps_t                 stamps,
	output logic                         empty,
	input  wire logic                    pop,
	output result_t                      result,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [31:0]             cfg_data
);

	localparam int MW        = 3 * STAMP_BITS + 4;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	logic [31:0] mm_per_tick_q;
	logic [15:0] offset_cm_q;

	logic          mid_wr, mid_rd, mid_full, mid_empty;
	logic [MW-1:0] mid_wdata, mid_rdata;
	logic          out_wr, out_full;
	result_t       out_wdata;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_per_tick_q <= MM_PER_TICK_RESET;
			offset_cm_q   <= OFFSET_CM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MM_PER_TICK: mm_per_tick_q <= cfg_data;
				REG_OFFSET_CM:   offset_cm_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	dtw_front #(.STAMP_BITS(STAMP_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.stamps   (stamps),
		.mid_wr   (mid_wr),
		.mid_data (mid_wdata),
		.mid_full (mid_full)
	);

	dtw_fifo #(.WIDTH(MW), .DEPTH(MID_DEPTH)) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (mid_wdata),
		.full    (mid_full),
		.rd_en   (mid_rd),
		.rd_data (mid_rdata),
		.empty   (mid_empty)
	);

	dtw_back #(.STAMP_BITS(STAMP_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.mid_empty       (mid_empty),
		.mid_data        (mid_rdata),
		.mid_rd          (mid_rd),
		.mm_per_tick_q24 (mm_per_tick_q),
		.offset_cm       (offset_cm_q),
		.out_full        (out_full),
		.out_wr          (out_wr),
		.out_data        (out_wdata)
	);

	dtw_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data (out_wdata),
		.full    (out_full),
		.rd_en   (pop && !empty),
		.rd_data (result),
		.empty   (empty)
	);

	// a zero divisor clears every other result field
	a_zero_div_clears: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.zero_divisor |->
			result.flight_ticks == 0 && result.distance_mm == 0 && !result.too_far)
		else $error("zero divisor item carries nonzero fields");

	// too far only for a positive flight time with a valid divisor
	a_far_positive: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.too_far |->
			!result.zero_divisor && !result.flight_ticks[31] && result.flight_ticks != 0)
		else $error("too far flag on a non-positive flight time");

	// the back end only takes from a nonempty middle queue
	a_mid_read: assert property (@(posedge clk) disable iff (!arst_n)
		mid_rd |-> !mid_empty)
		else $error("middle queue read while empty");

endmodule

`default_nettype wire

// ===== src/dtw_fifo.sv =====
// small register queue used between the stages of the distance unit
`timescale 1ns / 1ps
`default_nettype none

module dtw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	// depth is a power of two so the pointers wrap on their own
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/dtw_front.sv =====
// front end: interval forming, divisor check and the two cross products
`timescale 1ns / 1ps
`default_nettype none

module dtw_front import dtw_pkg::*; #(
	parameter int STAMP_BITS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire stamps_t                   stamps,
	output logic                           mid_wr,
	output logic [3*STAMP_BITS+3:0]        mid_data,
	input  wire logic                      mid_full
);

	localparam int S  = STAMP_BITS;
	localparam int P  = 2 * S;
	localparam int H  = (S + 1) / 2;
	localparam int G  = S - H;
	localparam int DW = S + 2;

	typedef struct packed {
		logic [P-1:0]  num;
		logic [DW-1:0] den;
		logic          neg;
		logic          zero;
	} mid_t;

	logic en;
	logic accept;

	logic v_s1, v_s2, v_s3, v_s4;

	logic [S-1:0] ra_s1, da_s1, rb_s1, db_s1;

	logic [DW-1:0]  den_s2;
	logic [2*H-1:0] ll1_s2, ll2_s2;
	logic [H+G-1:0] lh1_s2, hl1_s2, lh2_s2, hl2_s2;
	logic [2*G-1:0] hh1_s2, hh2_s2;

	logic [P-1:0]  p1_s3, p2_s3;
	logic [DW-1:0] den_s3;

	mid_t mid_s4;

	logic [S-1:0] t0, t1, t2, t3, t4, t5;
	logic [P:0]   diff;

	// the pipeline moves unless the last stage cannot hand off
	assign en     = !(v_s4 && mid_full);
	assign accept = push && en;
	assign full   = !en;
	assign mid_wr = v_s4 && !mid_full;
	assign mid_data = mid_s4;

	// stamps taken modulo the stamp width
	assign t0 = S'(stamps.tag_poll_tx);
	assign t1 = S'(stamps.tag_resp_rx);
	assign t2 = S'(stamps.tag_final_tx);
	assign t3 = S'(stamps.anchor_poll_rx);
	assign t4 = S'(stamps.anchor_resp_tx);
	assign t5 = S'(stamps.anchor_final_rx);

	// unsigned compare of the products; the borrow gives the sign of their difference
	assign diff = {1'b0, p1_s3} - {1'b0, p2_s3};

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: wrapping intervals
	always_ff @(posedge clk) begin
		if (en) begin
			ra_s1 <= t1 - t0;
			da_s1 <= t2 - t1;
			rb_s1 <= t5 - t4;
			db_s1 <= t4 - t3;
		end
	end

	// stage 2: interval sum and half-word partial products
	always_ff @(posedge clk) begin
		if (en) begin
			den_s2 <= DW'(ra_s1) + DW'(rb_s1) + DW'(da_s1) + DW'(db_s1);
			ll1_s2 <= ra_s1[H-1:0] * rb_s1[H-1:0];
			lh1_s2 <= ra_s1[H-1:0] * rb_s1[S-1:H];
			hl1_s2 <= ra_s1[S-1:H] * rb_s1[H-1:0];
			hh1_s2 <= ra_s1[S-1:H] * rb_s1[S-1:H];
			ll2_s2 <= da_s1[H-1:0] * db_s1[H-1:0];
			lh2_s2 <= da_s1[H-1:0] * db_s1[S-1:H];
			hl2_s2 <= da_s1[S-1:H] * db_s1[H-1:0];
			hh2_s2 <= da_s1[S-1:H] * db_s1[S-1:H];
		end
	end

	// stage 3: full products
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s3  <= (P'(hh1_s2) << (2 * H)) + (P'(lh1_s2) << H)
				+ (P'(hl1_s2) << H) + P'(ll1_s2);
			p2_s3  <= (P'(hh2_s2) << (2 * H)) + (P'(lh2_s2) << H)
				+ (P'(hl2_s2) << H) + P'(ll2_s2);
			den_s3 <= den_s2;
		end
	end

	// stage 4: numerator magnitude and sign
	always_ff @(posedge clk) begin
		if (en) begin
			mid_s4.neg  <= diff[P];
			mid_s4.num  <= diff[P] ? (p2_s3 - p1_s3) : diff[P-1:0];
			mid_s4.den  <= den_s3;
			mid_s4.zero <= (den_s3 == '0);
		end
	end

endmodule

`default_nettype wire

// ===== src/dtw_back.sv =====
// back end: pipelined restoring divider, tick scaling, offset and saturation
`timescale 1ns / 1ps
`default_nettype none

module dtw_back import dtw_pkg::*; #(
	parameter int STAMP_BITS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      mid_empty,
	input  wire logic [3*STAMP_BITS+3:0]   mid_data,
	output logic                           mid_rd,
	input  wire logic [31:0]               mm_per_tick_q24,
	input  wire logic [15:0]               offset_cm,
	input  wire logic                      out_full,
	output logic                           out_wr,
	output result_t                        out_data
);

	localparam int S  = STAMP_BITS;
	localparam int P  = 2 * S;
	localparam int DW = S + 2;
	localparam int ND = P;

	typedef struct packed {
		logic [P-1:0]  num;
		logic [DW-1:0] den;
		logic          neg;
		logic          zero;
	} mid_t;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [P-1:0]  num;
		logic [31:0]   quo;
		logic [DW-1:0] den;
		logic          neg;
		logic          zero;
	} div_t;

	// one quotient bit per stage
	function automatic div_t div_step(input div_t d);
		div_t          n;
		logic [DW:0]   rem_sh;
		logic [DW:0]   sub;
		logic          ge;
		n      = d;
		rem_sh = {d.rem, d.num[P-1]};
		sub    = rem_sh - {1'b0, d.den};
		ge     = (rem_sh >= {1'b0, d.den});
		n.rem  = ge ? sub[DW-1:0] : rem_sh[DW-1:0];
		n.num  = d.num << 1;
		n.quo  = {d.quo[30:0], ge};
		return n;
	endfunction

	logic en;
	mid_t head;
	div_t div_in;

	div_t div_s [1:ND];
	logic dv_s  [1:ND];

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [31:0]        tick_s1, tick_s2, tick_s3, tick_s4;
	logic               zero_s1, zero_s2, zero_s3, zero_s4;
	logic [31:0]        tmag_s2;
	logic [63:0]        prod_s3;
	logic signed [40:0] raw_s4;
	logic               far_s4;
	result_t            res_s5;

	logic [39:0]        raw_mag;
	logic signed [40:0] raw_val;
	logic               far;
	logic signed [19:0] off_ext;
	logic signed [19:0] off10;
	logic signed [42:0] dist_full;
	logic               ovf;

	assign en       = !(v_s5 && out_full);
	assign mid_rd   = !mid_empty && en;
	assign out_wr   = v_s5 && !out_full;
	assign out_data = res_s5;

	// divider entry from the queue head
	assign head = mid_data;
	always_comb begin
		div_in      = '0;
		div_in.num  = head.num;
		div_in.den  = head.den;
		div_in.neg  = head.neg;
		div_in.zero = head.zero;
	end

	// divider valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= ND; i++) begin
				dv_s[i] <= 1'b0;
			end
		end else if (en) begin
			dv_s[1] <= !mid_empty;
			for (int i = 2; i <= ND; i++) begin
				dv_s[i] <= dv_s[i-1];
			end
		end
	end

	// divider stages
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[1] <= div_step(div_in);
			for (int i = 2; i <= ND; i++) begin
				div_s[i] <= div_step(div_s[i-1]);
			end
		end
	end

	// tail valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= dv_s[ND];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// raw distance with the far clamp
	assign raw_mag = prod_s3[63:24];
	assign raw_val = tick_s3[31] ? -$signed({1'b0, raw_mag}) : $signed({1'b0, raw_mag});
	assign far     = !zero_s3 && !tick_s3[31] && (tick_s3 != '0)
		&& (prod_s3 > FAR_LIMIT_Q24);

	// offset times ten, subtract and saturate
	assign off_ext   = {{4{offset_cm[15]}}, offset_cm};
	assign off10     = (off_ext <<< 3) + (off_ext <<< 1);
	assign dist_full = 43'(raw_s4) - 43'(off10);
	assign ovf       = (dist_full[42:31] != {12{dist_full[31]}});

	// tail payload
	always_ff @(posedge clk) begin
		if (en) begin
			// signed ticks
			tick_s1 <= div_s[ND].neg ? (32'd0 - div_s[ND].quo) : div_s[ND].quo;
			zero_s1 <= div_s[ND].zero;

			// magnitude
			tmag_s2 <= tick_s1[31] ? (32'd0 - tick_s1) : tick_s1;
			tick_s2 <= tick_s1;
			zero_s2 <= zero_s1;

			// scale to q24 millimetres
			prod_s3 <= 64'(tmag_s2) * 64'(mm_per_tick_q24);
			tick_s3 <= tick_s2;
			zero_s3 <= zero_s2;

			raw_s4  <= far ? FAR_VALUE_MM : raw_val;
			far_s4  <= far;
			tick_s4 <= tick_s3;
			zero_s4 <= zero_s3;

			// result, all zero beside the flag for a zero divisor
			res_s5.zero_divisor <= zero_s4;
			res_s5.too_far      <= far_s4 && !zero_s4;
			res_s5.flight_ticks <= zero_s4 ? '0 : tick_s4;
			if (zero_s4) begin
				res_s5.distance_mm <= '0;
			end else if (ovf) begin
				res_s5.distance_mm <= dist_full[42] ? DIST_MIN : DIST_MAX;
			end else begin
				res_s5.distance_mm <= dist_full[31:0];
			end
		end
	end

endmodule

`default_nettype wire
